>>> rtl/analog_keypad_entry_decoder_macros.svh
// Assertion macros shared by the keypad entry decoder modules.
// Each macro expects clk_i and rst_ni in scope.
`ifndef ANALOG_KEYPAD_ENTRY_DECODER_MACROS_SVH
`define ANALOG_KEYPAD_ENTRY_DECODER_MACROS_SVH

// Same-cycle implication.
`define AKD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("keypad decoder check failed");

// Next-cycle implication.
`define AKD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("keypad decoder check failed");

`endif

>>> rtl/akd_pkg.sv
`timescale 1ns / 1ps

package akd_pkg;

  localparam int ENTRY_DIGITS_DEF = 4;
  localparam int SAMPLE_BITS_DEF  = 12;

  localparam int CODE_W      = 4;
  localparam int ECHO_W      = 7;
  localparam int COUNT_OUT_W = 3;
  localparam int VALUE_W     = 15;

  localparam logic [CODE_W-1:0] ACCEPT_CODE = 4'd13;

  // Decoded sample: window hit with key code, or echo of an idle line.
  typedef struct packed {
    logic              hit;
    logic              echo_on;
    logic [CODE_W-1:0] code;
    logic [ECHO_W-1:0] echo;
  } akd_key_t;

  // Entry store outcome for one item.
  typedef struct packed {
    logic                   accepted;
    logic [COUNT_OUT_W-1:0] count;
    logic [VALUE_W-1:0]     value;
  } akd_entry_t;

endpackage

>>> rtl/analog_keypad_entry_decoder.sv
`timescale 1ns / 1ps
`include "analog_keypad_entry_decoder_macros.svh"

// Resistor-ladder keypad decoder with a small digit entry buffer. Each slave
// item is one ADC sample; it is matched against sixteen open voltage windows
// in fixed order (first match wins) and yields a key code and its ASCII echo,
// or a space echo when the line is idle (sample below 50). Every key but D
// appends its code to an ENTRY_DIGITS deep buffer; once full, further codes
// are dropped while the key is still reported. Key D accepts: it returns the
// weighted decimal value of the whole buffer (first entry most significant,
// wrapped to 15 bits) and resets the count without clearing the buffer.
// Every sample yields exactly one master item. The block sustains one item
// per clock while m_axis_tready is high: a sample is captured in an input
// register, decoded and applied to the buffer, and lands in the output
// register that drives m_axis_tvalid. The output register stalls only on
// m_axis_tready; the slave side stalls only while both the input and
// output registers are full and m_axis_tready is low. No clearing pass
// follows reset.
module analog_keypad_entry_decoder
  import akd_pkg::*;
#(
  parameter int ENTRY_DIGITS = ENTRY_DIGITS_DEF,
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Sample items.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: adc_sample, zero padded to whole bytes
  input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // Result items.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: key_code[3:0], echo_char[10:4], digit_count[13:11],
  //        entered_value[28:14], zero padding [31:29]
  output logic [31:0] m_axis_tdata,
  // tuser: key_valid[0], echo_valid[1], accepted[2]
  output logic [2:0]  m_axis_tuser
);

  localparam int OUT_PAD = 32 - (CODE_W + ECHO_W + COUNT_OUT_W + VALUE_W);

  // Input stage.
  logic                   in_valid_q;
  logic [SAMPLE_BITS-1:0] in_sample_q;

  // Output stage.
  logic                   out_valid_q;
  logic                   key_valid_q;
  logic                   echo_valid_q;
  logic                   accepted_q;
  logic [CODE_W-1:0]      key_code_q;
  logic [ECHO_W-1:0]      echo_char_q;
  logic [COUNT_OUT_W-1:0] count_q;
  logic [VALUE_W-1:0]     value_q;

  logic       advance;
  akd_key_t   key;
  akd_entry_t entry;

  // Move the held sample into the output register whenever that is free
  // or being drained this cycle.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_sample_q <= s_axis_tdata[SAMPLE_BITS-1:0];
    end
  end

  akd_window_decode #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_decode (
    .sample_i(in_sample_q),
    .key_o   (key)
  );

  // Buffer state updates only when the item actually advances.
  akd_entry_store #(
    .ENTRY_DIGITS(ENTRY_DIGITS)
  ) u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .key_i  (key),
    .entry_o(entry)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      key_valid_q  <= key.hit;
      echo_valid_q <= key.echo_on;
      key_code_q   <= key.code;
      echo_char_q  <= key.echo;
      accepted_q   <= entry.accepted;
      count_q      <= entry.count;
      value_q      <= entry.value;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{OUT_PAD{1'b0}}, value_q, count_q, echo_char_q, key_code_q};
  assign m_axis_tuser  = {accepted_q, echo_valid_q, key_valid_q};

  `AKD_ASSERT_IMP(a_stall_only_full, !s_axis_tready,
                  in_valid_q && out_valid_q && !m_axis_tready)
  `AKD_ASSERT_IMP(a_accept_is_d, out_valid_q && accepted_q,
                  key_valid_q && (key_code_q == ACCEPT_CODE) && (count_q == '0))
  `AKD_ASSERT_IMP(a_miss_clean, out_valid_q && !key_valid_q,
                  (key_code_q == '0) && !accepted_q && (value_q == '0))

endmodule

>>> rtl/akd_window_decode.sv
`timescale 1ns / 1ps

module akd_window_decode
  import akd_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic [SAMPLE_BITS-1:0] sample_i,
  output akd_key_t               key_o
);

  localparam int CMP_W     = 16;
  localparam int WIN_COUNT = 16;

  localparam logic [CMP_W-1:0] IDLE_LIMIT = 16'd50;
  localparam logic [ECHO_W-1:0] ECHO_SPACE = 7'h20;

  // Open windows, lowest index wins.
  localparam logic [CMP_W-1:0] WIN_LO [WIN_COUNT] = '{
    16'd3700, 16'd3500, 16'd3300, 16'd3030, 16'd2900, 16'd2800, 16'd2680, 16'd2490,
    16'd2340, 16'd2290, 16'd2190, 16'd2060, 16'd2000, 16'd1940, 16'd1887, 16'd1780
  };
  localparam logic [CMP_W-1:0] WIN_HI [WIN_COUNT] = '{
    16'd3900, 16'd3650, 16'd3400, 16'd3050, 16'd3000, 16'd2900, 16'd2705, 16'd2502,
    16'd2400, 16'd2310, 16'd2210, 16'd2080, 16'd2030, 16'd1970, 16'd1895, 16'd1795
  };
  localparam logic [CODE_W-1:0] WIN_CODE [WIN_COUNT] = '{
    4'd1, 4'd2, 4'd3, 4'd10, 4'd4, 4'd5, 4'd6, 4'd11,
    4'd7, 4'd8, 4'd9, 4'd12, 4'd14, 4'd0, 4'd15, 4'd13
  };
  localparam logic [ECHO_W-1:0] WIN_ECHO [WIN_COUNT] = '{
    7'h31, 7'h32, 7'h33, 7'h41, 7'h34, 7'h35, 7'h36, 7'h42,
    7'h37, 7'h38, 7'h39, 7'h43, 7'h2A, 7'h30, 7'h23, 7'h44
  };

  logic [CMP_W-1:0]     sample_ext;
  logic [WIN_COUNT-1:0] in_win;

  assign sample_ext = CMP_W'(sample_i);

  always_comb begin
    for (int i = 0; i < WIN_COUNT; i++) begin
      in_win[i] = (sample_ext > WIN_LO[i]) && (sample_ext < WIN_HI[i]);
    end
  end

  // Walk from the back so the first matching window is the one kept.
  always_comb begin
    key_o = '0;
    for (int i = WIN_COUNT - 1; i >= 0; i--) begin
      if (in_win[i]) begin
        key_o.hit     = 1'b1;
        key_o.echo_on = 1'b1;
        key_o.code    = WIN_CODE[i];
        key_o.echo    = WIN_ECHO[i];
      end
    end
    if (!key_o.hit && (sample_ext < IDLE_LIMIT)) begin
      key_o.echo_on = 1'b1;
      key_o.echo    = ECHO_SPACE;
    end
  end

endmodule

>>> rtl/akd_entry_store.sv
`timescale 1ns / 1ps
`include "analog_keypad_entry_decoder_macros.svh"

module akd_entry_store
  import akd_pkg::*;
#(
  parameter int ENTRY_DIGITS = ENTRY_DIGITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  akd_key_t   key_i,
  output akd_entry_t entry_o
);

  localparam int CNT_W = $clog2(ENTRY_DIGITS + 1);
  localparam int IDX_W = (ENTRY_DIGITS > 1) ? $clog2(ENTRY_DIGITS) : 1;

  logic [CODE_W-1:0] store_q [ENTRY_DIGITS];
  logic [CNT_W-1:0]  count_q, count_d;
  logic              is_accept;
  logic              do_write;
  logic [VALUE_W-1:0] value;

  assign is_accept = key_i.hit && (key_i.code == ACCEPT_CODE);
  assign do_write  = key_i.hit && !is_accept && (count_q < CNT_W'(ENTRY_DIGITS));

  // Weighted decimal value, first entry most significant; wraps to VALUE_W.
  always_comb begin
    value = '0;
    for (int i = 0; i < ENTRY_DIGITS; i++) begin
      value = VALUE_W'((value << 3) + (value << 1) + VALUE_W'(store_q[i]));
    end
  end

  always_comb begin
    count_d = count_q;
    priority if (is_accept) begin
      count_d = '0;
    end else if (do_write) begin
      count_d = CNT_W'(count_q + 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      for (int i = 0; i < ENTRY_DIGITS; i++) begin
        store_q[i] <= '0;
      end
    end else if (step_i) begin
      count_q <= count_d;
      if (do_write) begin
        store_q[count_q[IDX_W-1:0]] <= key_i.code;
      end
    end
  end

  assign entry_o.accepted = is_accept;
  assign entry_o.count    = COUNT_OUT_W'(count_d);
  assign entry_o.value    = is_accept ? value : '0;

  `AKD_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CNT_W'(ENTRY_DIGITS))
  `AKD_ASSERT_NEXT(a_miss_holds, step_i && !key_i.hit, count_q == $past(count_q))
  `AKD_ASSERT_NEXT(a_accept_clears, step_i && is_accept, count_q == '0)

endmodule
